>>> hdl/sorted_appointment_table_assert.svh
// Assertion macros for the appointment table checker.
`ifndef SORTED_APPOINTMENT_TABLE_ASSERT_SVH
`define SORTED_APPOINTMENT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sat_pkg.sv
package sat_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int NAME_BYTES_DEFAULT = 8;

    localparam int KEY_W      = 16;
    localparam int NAME_TAG_W = 64;
    localparam int TOTAL_W    = 5;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_SAME_TIME = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic ins_en;
        logic del_en;
    } cell_ctl_t;

    typedef struct packed {
        logic ge;
        logic dup;
        logic hit;
    } cell_flags_t;

endpackage

>>> hdl/sat_cell.sv
module sat_cell #(
    parameter int NAME_W = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sat_pkg::cell_ctl_t        ctl,
    input  logic [sat_pkg::KEY_W-1:0] new_key,
    input  logic [NAME_W-1:0]         new_name,
    input  logic [sat_pkg::KEY_W-1:0] prev_key,
    input  logic [NAME_W-1:0]         prev_name,
    input  logic                      prev_occ,
    input  logic                      prev_ge,
    input  logic [sat_pkg::KEY_W-1:0] next_key,
    input  logic [NAME_W-1:0]         next_name,
    input  logic                      next_occ,
    input  logic                      hit_in,
    output logic [sat_pkg::KEY_W-1:0] key,
    output logic [NAME_W-1:0]         name,
    output logic                      occ,
    output sat_pkg::cell_flags_t      flags
);

    logic [sat_pkg::KEY_W-1:0] key_reg,  key_next;
    logic [NAME_W-1:0]         name_reg, name_next;
    logic                      occ_reg,  occ_next;
    logic                      is_pos;
    logic                      match;

    assign flags.ge  = !occ_reg || (key_reg >= new_key);
    assign is_pos    = flags.ge && !prev_ge;
    assign flags.dup = is_pos && occ_reg && (key_reg == new_key);
    assign match     = occ_reg && (name_reg == new_name);
    assign flags.hit = hit_in || match;

    always_comb begin
        key_next  = key_reg;
        name_next = name_reg;
        occ_next  = occ_reg;
        if (ctl.ins_en && flags.ge) begin
            if (is_pos) begin
                key_next  = new_key;
                name_next = new_name;
                occ_next  = 1'b1;
            end else begin
                key_next  = prev_key;
                name_next = prev_name;
                occ_next  = prev_occ;
            end
        end else if (ctl.del_en && flags.hit) begin
            key_next  = next_key;
            name_next = next_name;
            occ_next  = next_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        key_reg  <= key_next;
        name_reg <= name_next;
    end

    assign key  = key_reg;
    assign name = name_reg;
    assign occ  = occ_reg;

endmodule

>>> hdl/sorted_appointment_table.sv
// Sorted appointment table.
// Input channel s_*: one request per item. s_cmd selects insert (keyed by
// s_day, s_hour, s_minute, carrying s_name_tag) or delete by name tag.
// Output channel m_*: exactly one result per request, in request order,
// with m_status, m_entry_total (count masked to 5 bits) and m_is_empty.
// Storage is a row of DEPTH cells kept in key order; every cell compares
// itself against the request and shifts from its neighbor as the row updates.
// An accepted request waits in the request register until the output
// register is free; its result is then registered there for the m_ ports.
// The request register holds one item at a time while the cell row updates;
// s_ready is low while it is full, so a new request waits until it empties.
// A result that the receiver stalls stays in the output register; the
// next request is still accepted and waits in the request register.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// request or result.
module sorted_appointment_table #(
    parameter int DEPTH      = sat_pkg::DEPTH_DEFAULT,
    parameter int NAME_BYTES = sat_pkg::NAME_BYTES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [4:0]                     s_day,
    input  logic [4:0]                     s_hour,
    input  logic [5:0]                     s_minute,
    input  logic [sat_pkg::NAME_TAG_W-1:0] s_name_tag,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [sat_pkg::TOTAL_W-1:0]    m_entry_total,
    output logic                           m_is_empty
);

    localparam int NAME_W = NAME_BYTES * 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                      req_valid_reg;
    sat_pkg::cmd_t             cmd_reg;
    logic [sat_pkg::KEY_W-1:0] key_reg;
    logic [NAME_W-1:0]         name_reg;

    logic [CNT_W-1:0] count_reg, count_next;

    logic                          m_valid_reg;
    sat_pkg::status_t              m_status_reg, status_next;
    logic [sat_pkg::TOTAL_W-1:0]   m_total_reg;
    logic                          m_empty_reg;
    logic [CNT_W+sat_pkg::TOTAL_W-1:0] total_wide;

    logic                 s_fire;
    logic                 proc;
    logic                 full;
    logic                 dup_any;
    logic                 found;
    sat_pkg::cell_ctl_t   ctl;

    logic [sat_pkg::KEY_W-1:0] cell_key  [DEPTH];
    logic [NAME_W-1:0]         cell_name [DEPTH];
    logic                      cell_occ  [DEPTH];
    sat_pkg::cell_flags_t      cell_flags[DEPTH];
    logic [DEPTH-1:0]          dup_vec;

    assign s_ready = !req_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign proc    = req_valid_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_fire) begin
            req_valid_reg <= 1'b1;
        end else if (proc) begin
            req_valid_reg <= 1'b0;
        end
        if (s_fire) begin
            cmd_reg  <= sat_pkg::cmd_t'(s_cmd);
            key_reg  <= {s_day, s_hour, s_minute};
            name_reg <= s_name_tag[NAME_W-1:0];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [sat_pkg::KEY_W-1:0] p_key, n_key;
            logic [NAME_W-1:0]         p_name, n_name;
            logic                      p_occ, p_ge, n_occ, h_in;

            if (gi == 0) begin : g_first
                assign p_key  = '0;
                assign p_name = '0;
                assign p_occ  = 1'b0;
                assign p_ge   = 1'b0;
                assign h_in   = 1'b0;
            end else begin : g_mid
                assign p_key  = cell_key[gi-1];
                assign p_name = cell_name[gi-1];
                assign p_occ  = cell_occ[gi-1];
                assign p_ge   = cell_flags[gi-1].ge;
                assign h_in   = cell_flags[gi-1].hit;
            end

            if (gi == DEPTH - 1) begin : g_last
                assign n_key  = '0;
                assign n_name = '0;
                assign n_occ  = 1'b0;
            end else begin : g_inner
                assign n_key  = cell_key[gi+1];
                assign n_name = cell_name[gi+1];
                assign n_occ  = cell_occ[gi+1];
            end

            sat_cell #(
                .NAME_W(NAME_W)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .new_key  (key_reg),
                .new_name (name_reg),
                .prev_key (p_key),
                .prev_name(p_name),
                .prev_occ (p_occ),
                .prev_ge  (p_ge),
                .next_key (n_key),
                .next_name(n_name),
                .next_occ (n_occ),
                .hit_in   (h_in),
                .key      (cell_key[gi]),
                .name     (cell_name[gi]),
                .occ      (cell_occ[gi]),
                .flags    (cell_flags[gi])
            );

            assign dup_vec[gi] = cell_flags[gi].dup;
        end
    endgenerate

    assign full    = cell_occ[DEPTH-1];
    assign dup_any = |dup_vec;
    assign found   = cell_flags[DEPTH-1].hit;

    always_comb begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = sat_pkg::ST_NOT_FOUND;
        if (cmd_reg == sat_pkg::CMD_INSERT) begin
            if (full) begin
                status_next = sat_pkg::ST_FULL;
            end else if (dup_any) begin
                status_next = sat_pkg::ST_SAME_TIME;
            end else begin
                status_next = sat_pkg::ST_INSERTED;
                ctl.ins_en  = proc;
                count_next  = count_reg + CNT_W'(1);
            end
        end else begin
            if (found) begin
                status_next = sat_pkg::ST_DELETED;
                ctl.del_en  = proc;
                count_next  = count_reg - CNT_W'(1);
            end
        end
    end

    assign total_wide = {{sat_pkg::TOTAL_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (proc) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (proc) begin
            m_status_reg <= status_next;
            m_total_reg  <= total_wide[sat_pkg::TOTAL_W-1:0];
            m_empty_reg  <= (count_next == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_total = m_total_reg;
    assign m_is_empty    = m_empty_reg;

endmodule

>>> hdl/sat_checker.sv
`include "sorted_appointment_table_assert.svh"

module sat_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [2:0]                     m_status,
    input logic [sat_pkg::TOTAL_W-1:0]    m_entry_total,
    input logic                           m_is_empty
);

    `SAT_ASSERT_NOW(a_empty_total, m_valid && m_is_empty, m_entry_total == '0, "empty with nonzero total")

    `SAT_ASSERT_NOW(a_full_not_empty, m_valid && (m_status == sat_pkg::ST_FULL || m_status == sat_pkg::ST_INSERTED), !m_is_empty, "full or insert reported on empty table")

    `SAT_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second request taken while one is pending")

    `SAT_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_entry_total), "stalled result changed")

endmodule

bind sorted_appointment_table sat_checker u_sat_checker (.*);
